/* hw/rtl/stq_pkg.sv */
// Shared types and constants of the sorted timer queue.
// Used by stq_ctrl, stq_dp and sorted_timer_queue; depends on nothing.
package stq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef enum logic [1:0] {
    ACT_ADD_REL = 2'd0,
    ACT_ADD_ABS = 2'd1,
    ACT_POLL    = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    KIND_ADDED   = 3'd0,
    KIND_ABORTED = 3'd1,
    KIND_FULL    = 3'd2,
    KIND_EXPIRED = 3'd3,
    KIND_DONE    = 3'd4
  } res_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_INSERT,
    ST_POLL
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now;
    logic [31:0] amount;
    logic [7:0]  owner;
    logic [4:0]  signal_number;
  } req_t;

  typedef struct packed {
    res_kind_e   kind;
    logic [7:0]  owner_res;
    logic [4:0]  signal_number_res;
    logic [31:0] expiry;
    logic        last;
  } res_t;

  // Controller to datapath.
  typedef struct packed {
    logic      load;       // capture request, compute expiry tick
    logic      ins_init;   // start insertion scan at the tail
    logic      ins_shift;  // move entry one slot up, step index down
    logic      ins_write;  // write new timer at index, grow count
    logic      pop;        // drop head entry, shift all down
    logic      emit;       // load result register
    res_kind_e kind;
    logic      last;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_add;
    logic is_poll;
    logic elapsed;
    logic full;
    logic ins_stop;
    logic head_expired;
  } status_t;

endpackage

/* hw/rtl/stq_ctrl.sv */
// Sequencer of the sorted timer queue: evaluates, inserts, polls.
// Depends on stq_pkg; drives stq_dp through cmd_t, reads status_t.
module stq_ctrl import stq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (status_i.is_add && !status_i.elapsed && !status_i.full) begin
          state_d = ST_INSERT;
        end else if (status_i.is_poll) begin
          state_d = ST_POLL;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_INSERT: begin
        if (status_i.ins_stop) state_d = ST_IDLE;
      end
      ST_POLL: begin
        if (!status_i.head_expired) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.kind = KIND_DONE;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = start_i;
      end
      ST_EVAL: begin
        if (status_i.is_add) begin
          if (status_i.elapsed) begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = KIND_ABORTED;
            cmd_o.last = 1'b1;
          end else if (status_i.full) begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = KIND_FULL;
            cmd_o.last = 1'b1;
          end else begin
            cmd_o.ins_init = 1'b1;
          end
        end
      end
      ST_INSERT: begin
        if (status_i.ins_stop) begin
          cmd_o.ins_write = 1'b1;
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_ADDED;
          cmd_o.last = 1'b1;
        end else begin
          cmd_o.ins_shift = 1'b1;
        end
      end
      ST_POLL: begin
        cmd_o.emit = 1'b1;
        if (status_i.head_expired) begin
          cmd_o.pop = 1'b1;
          cmd_o.kind = KIND_EXPIRED;
        end else begin
          cmd_o.kind = KIND_DONE;
          cmd_o.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

/* hw/rtl/stq_dp.sv */
// Datapath of the sorted timer queue: request latch, sorted entry store,
// fill count, insertion index and result register. Depends on stq_pkg.
module stq_dp import stq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  req_t    req_i,
  input  cmd_t    cmd_i,
  output status_t status_o,
  output logic    res_valid_o,
  output res_t    res_o
);

  logic [31:0] expiry_q [QUEUE_DEPTH];
  logic [7:0]  owner_q  [QUEUE_DEPTH];
  logic [4:0]  signal_q [QUEUE_DEPTH];

  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] idx_q;
  logic [1:0]       action_q;
  logic [31:0]      now_q;
  logic [31:0]      tick_q;
  logic [7:0]       owner_r_q;
  logic [4:0]       signal_r_q;
  logic             res_valid_q;
  res_t             res_q;

  logic [IDX_W-1:0] idx_prev;
  assign idx_prev = idx_q - IDX_W'(1);

  // Request latch; the expiry tick is formed here.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q   <= req_i.action;
      now_q      <= req_i.now;
      owner_r_q  <= req_i.owner;
      signal_r_q <= req_i.signal_number;
      tick_q     <= (req_i.action == ACT_ADD_REL) ? (req_i.now + req_i.amount)
                                                  : req_i.amount;
    end
  end

  // Entry store, no reset: only entries below the count are read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        expiry_q[i] <= expiry_q[i + 1];
        owner_q[i]  <= owner_q[i + 1];
        signal_q[i] <= signal_q[i + 1];
      end
    end else if (cmd_i.ins_shift) begin
      expiry_q[idx_q] <= expiry_q[idx_prev];
      owner_q[idx_q]  <= owner_q[idx_prev];
      signal_q[idx_q] <= signal_q[idx_prev];
    end else if (cmd_i.ins_write) begin
      expiry_q[idx_q] <= tick_q;
      owner_q[idx_q]  <= owner_r_q;
      signal_q[idx_q] <= signal_r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_init) begin
      idx_q <= count_q[IDX_W-1:0];
    end else if (cmd_i.ins_shift) begin
      idx_q <= idx_prev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ins_write) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.pop) begin
        count_q <= count_q - CNT_W'(1);
      end
      res_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q.kind <= cmd_i.kind;
      res_q.last <= cmd_i.last;
      if (cmd_i.pop) begin
        res_q.owner_res         <= owner_q[0];
        res_q.signal_number_res <= signal_q[0];
        res_q.expiry            <= expiry_q[0];
      end else if (cmd_i.kind == KIND_DONE) begin
        res_q.owner_res         <= '0;
        res_q.signal_number_res <= '0;
        res_q.expiry            <= '0;
      end else begin
        res_q.owner_res         <= owner_r_q;
        res_q.signal_number_res <= signal_r_q;
        res_q.expiry            <= tick_q;
      end
    end
  end

  assign status_o.is_add       = (action_q == ACT_ADD_REL) || (action_q == ACT_ADD_ABS);
  assign status_o.is_poll      = (action_q == ACT_POLL);
  assign status_o.elapsed      = (tick_q <= now_q);
  assign status_o.full         = (count_q >= CNT_W'(QUEUE_DEPTH));
  assign status_o.ins_stop     = (idx_q == '0) || (expiry_q[idx_prev] <= tick_q);
  assign status_o.head_expired = (count_q != '0) && (expiry_q[0] <= now_q);

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (count_q != '0))
    else $error("pop from empty queue");

  a_write_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_write |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the count");

  a_one_store_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.pop, cmd_i.ins_shift, cmd_i.ins_write}))
    else $error("conflicting store operations");

endmodule

/* hw/rtl/sorted_timer_queue.sv */
// Top level of the sorted timer queue: joins controller and datapath.
// Depends on stq_pkg, stq_ctrl and stq_dp.
//
// Usage:
//   Request channel: drive req_i and raise start_i; the request is taken at
//   a rising edge where start_i is high and busy_o is low. busy_o stays high
//   until the request's last result has been loaded into the result register.
//   Result channel: res_valid_o is high for exactly one cycle per result, with
//   res_o holding kind, owner, signal number, expiry tick and the last flag.
//   The receiver cannot stall; every strobe must be taken.
// Timing:
//   An aborted or full add: result formed in the evaluate step, with no insertion.
//   A successful add walks the sorted store from the tail, one entry per
//   cycle, shifting each entry with a later tick up one slot; its result
//   is emitted with the final write of the new timer.
//   A poll pops one expired head entry per cycle: n expired results, then the
//   done marker, one per cycle.
//   A new request may be taken in the cycle its predecessor's last result is
//   on the ports. Unused action codes give no result.
// Reset: rst_ni clears the fill count (queue empty) and the controller.
module sorted_timer_queue import stq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic res_valid_o,
  output res_t res_o
);

  cmd_t    cmd;
  status_t status;

  // Hold the sequence of evaluate, insert or poll steps.
  stq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Store the sorted entries and form results.
  stq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench of the sorted timer queue: directed table, then random requests.
// Depends on stq_pkg and the sorted_timer_queue RTL; every result is checked against a typed value or a mirror.
module tb_top;
  import stq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Action code that the block ignores: no result, no change to the queue.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Cycles to hold after the last expected result, enough for an ignored request to finish.
  localparam int SETTLE_CYCLES = QUEUE_DEPTH + 4;
  localparam int RAND_ITEMS = 256;
  // Run no idle gaps in this many final random requests.
  localparam int CALM_ITEMS = 40;
  localparam int DIR_ROWS = 27;

  // One row of the directed table. When has_want is set, the single result is typed in.
  typedef struct {
    req_t req;
    bit   has_want;
    res_t want;
  } stim_row_t;

  localparam res_t UNTYPED = '{KIND_DONE, 8'd0, 5'd0, 32'd0, 1'b0};

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o;
  logic res_valid_o;
  res_t res_o;

  sorted_timer_queue u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Mirror of the timer queue: sorted by tick, oldest first, with its fill level.
  // ---------------------------------------------------------------------------
  logic [31:0] mirror_tick  [QUEUE_DEPTH];
  logic [7:0]  mirror_owner [QUEUE_DEPTH];
  logic [4:0]  mirror_sig   [QUEUE_DEPTH];
  int          mirror_fill = 0;

  // Results still owed by the block, oldest first.
  res_t pending_results[$];

  int fail_count = 0;
  int requests_sent = 0;
  int seen_added = 0;
  int seen_aborted = 0;
  int seen_full = 0;
  int seen_expired = 0;
  int seen_polls = 0;

  // Apply one accepted request to the mirror; queue its results when keep is set.
  task automatic mirror_request(input req_t r, input bit keep);
    logic [31:0] tick;
    int          pos;
    int          n;
    res_t        outs[$];
    case (r.action)
      ACT_ADD_REL, ACT_ADD_ABS: begin
        // Relative delay wraps modulo 2^32 and is compared as is.
        tick = (r.action == ACT_ADD_REL) ? r.now + r.amount : r.amount;
        if (tick <= r.now) begin
          outs.push_back('{KIND_ABORTED, r.owner, r.signal_number, tick, 1'b1});
        end else if (mirror_fill == QUEUE_DEPTH) begin
          outs.push_back('{KIND_FULL, r.owner, r.signal_number, tick, 1'b1});
        end else begin
          // Insert after every entry with an equal or earlier tick.
          pos = 0;
          while (pos < mirror_fill && mirror_tick[pos] <= tick) pos++;
          for (int i = mirror_fill; i > pos; i--) begin
            mirror_tick[i]  = mirror_tick[i-1];
            mirror_owner[i] = mirror_owner[i-1];
            mirror_sig[i]   = mirror_sig[i-1];
          end
          mirror_tick[pos]  = tick;
          mirror_owner[pos] = r.owner;
          mirror_sig[pos]   = r.signal_number;
          mirror_fill++;
          outs.push_back('{KIND_ADDED, r.owner, r.signal_number, tick, 1'b1});
        end
      end
      ACT_POLL: begin
        // Pop every leading entry that has elapsed, then close with the done marker.
        n = 0;
        while (n < mirror_fill && mirror_tick[n] <= r.now) begin
          outs.push_back('{KIND_EXPIRED, mirror_owner[n], mirror_sig[n], mirror_tick[n], 1'b0});
          n++;
        end
        for (int i = n; i < mirror_fill; i++) begin
          mirror_tick[i-n]  = mirror_tick[i];
          mirror_owner[i-n] = mirror_owner[i];
          mirror_sig[i-n]   = mirror_sig[i];
        end
        mirror_fill -= n;
        outs.push_back('{KIND_DONE, 8'd0, 5'd0, 32'd0, 1'b1});
      end
      default: ;
    endcase
    if (keep) begin
      foreach (outs[i]) pending_results.push_back(outs[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request driver. Drain every owed result first when drain is set, then idle
  // for gap cycles; then hold start until the block takes the request.
  // Only one nonblocking write of start_i happens per edge.
  // ---------------------------------------------------------------------------
  task automatic issue_request(input req_t r, input int gap, input bit drain);
    if (drain || gap > 0) begin
      start_i <= 1'b0;
      if (drain) begin
        while (pending_results.size() != 0) @(posedge clk_i);
        repeat (SETTLE_CYCLES) @(posedge clk_i);
      end
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    // Accepted at the first edge where busy was low.
    do @(posedge clk_i); while (busy_o);
    requests_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest owed result.
  // Outputs are read at the edge, before the block updates them.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d owner %h sig %0d expiry %h last %b",
                 $time, res_o.kind, res_o.owner_res, res_o.signal_number_res, res_o.expiry,
                 res_o.last);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_o.kind !== want.kind || res_o.owner_res !== want.owner_res ||
            res_o.signal_number_res !== want.signal_number_res ||
            res_o.expiry !== want.expiry || res_o.last !== want.last) begin
          $display("%0t: result mismatch, expected kind %0d owner %h sig %0d expiry %h last %b",
                   $time, want.kind, want.owner_res, want.signal_number_res, want.expiry,
                   want.last);
          $display("%0t:                    got kind %0d owner %h sig %0d expiry %h last %b",
                   $time, res_o.kind, res_o.owner_res, res_o.signal_number_res, res_o.expiry,
                   res_o.last);
          fail_count++;
        end
        case (want.kind)
          KIND_ADDED:   seen_added++;
          KIND_ABORTED: seen_aborted++;
          KIND_FULL:    seen_full++;
          KIND_EXPIRED: seen_expired++;
          default:      seen_polls++;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table. Typed rows: after reset, extremes, aborted, added and full.
  // The rest are checked against the mirror.
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [DIR_ROWS] = '{
    // Poll of the empty queue right after reset.
    '{'{ACT_POLL, 32'd0, 32'd0, 8'h00, 5'd0}, 1'b1,
      '{KIND_DONE, 8'h00, 5'd0, 32'd0, 1'b1}},
    // Zero delay.
    '{'{ACT_ADD_REL, 32'd0, 32'd0, 8'h00, 5'd0}, 1'b1,
      '{KIND_ABORTED, 8'h00, 5'd0, 32'd0, 1'b1}},
    // Delay sum wraps to zero.
    '{'{ACT_ADD_REL, 32'hFFFF_FFFF, 32'd1, 8'hFF, 5'd31}, 1'b1,
      '{KIND_ABORTED, 8'hFF, 5'd31, 32'd0, 1'b1}},
    // Alarm equal to now, then in the past.
    '{'{ACT_ADD_ABS, 32'd100, 32'd100, 8'h5A, 5'd10}, 1'b1,
      '{KIND_ABORTED, 8'h5A, 5'd10, 32'd100, 1'b1}},
    '{'{ACT_ADD_ABS, 32'd100, 32'd50, 8'hA5, 5'd21}, 1'b1,
      '{KIND_ABORTED, 8'hA5, 5'd21, 32'd50, 1'b1}},
    // Largest delay from the largest now wraps just below now.
    '{'{ACT_ADD_REL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h01, 5'd1}, 1'b1,
      '{KIND_ABORTED, 8'h01, 5'd1, 32'hFFFF_FFFE, 1'b1}},
    // Latest possible alarm.
    '{'{ACT_ADD_ABS, 32'd0, 32'hFFFF_FFFF, 8'hFF, 5'd31}, 1'b1,
      '{KIND_ADDED, 8'hFF, 5'd31, 32'hFFFF_FFFF, 1'b1}},
    // Two equal ticks: the second goes behind the first.
    '{'{ACT_ADD_REL, 32'd10, 32'd5, 8'h01, 5'd1}, 1'b1,
      '{KIND_ADDED, 8'h01, 5'd1, 32'd15, 1'b1}},
    '{'{ACT_ADD_REL, 32'd10, 32'd5, 8'h02, 5'd2}, 1'b1,
      '{KIND_ADDED, 8'h02, 5'd2, 32'd15, 1'b1}},
    // New head of the queue.
    '{'{ACT_ADD_ABS, 32'd0, 32'd1, 8'h03, 5'd3}, 1'b1,
      '{KIND_ADDED, 8'h03, 5'd3, 32'd1, 1'b1}},
    // Unused action with every bit set: ignored.
    '{'{ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 5'd31}, 1'b0, UNTYPED},
    '{'{ACT_ADD_REL, 32'd0, 32'h7FFF_FFFF, 8'h80, 5'd16}, 1'b1,
      '{KIND_ADDED, 8'h80, 5'd16, 32'h7FFF_FFFF, 1'b1}},
    // Fill the rest of the store, inserting between the existing entries.
    '{'{ACT_ADD_ABS, 32'd2, 32'd15, 8'h10, 5'd4}, 1'b0, UNTYPED},
    '{'{ACT_ADD_ABS, 32'd2, 32'd3, 8'h11, 5'd5}, 1'b0, UNTYPED},
    '{'{ACT_ADD_ABS, 32'd2, 32'd500, 8'h12, 5'd6}, 1'b0, UNTYPED},
    '{'{ACT_ADD_ABS, 32'd2, 32'd40, 8'h13, 5'd7}, 1'b0, UNTYPED},
    '{'{ACT_ADD_ABS, 32'd2, 32'd40, 8'h14, 5'd8}, 1'b0, UNTYPED},
    '{'{ACT_ADD_ABS, 32'd2, 32'd2000, 8'h15, 5'd9}, 1'b0, UNTYPED},
    '{'{ACT_ADD_ABS, 32'd2, 32'd9, 8'h16, 5'd11}, 1'b0, UNTYPED},
    '{'{ACT_ADD_ABS, 32'd2, 32'd100000, 8'h17, 5'd12}, 1'b0, UNTYPED},
    '{'{ACT_ADD_ABS, 32'd2, 32'h7FFF_FFFF, 8'h18, 5'd13}, 1'b0, UNTYPED},
    '{'{ACT_ADD_ABS, 32'd2, 32'd16, 8'h19, 5'd14}, 1'b0, UNTYPED},
    '{'{ACT_ADD_ABS, 32'd2, 32'd1000, 8'h1A, 5'd15}, 1'b0, UNTYPED},
    // Store is full.
    '{'{ACT_ADD_REL, 32'd0, 32'd1, 8'h44, 5'd4}, 1'b1,
      '{KIND_FULL, 8'h44, 5'd4, 32'd1, 1'b1}},
    // Elapsed check wins over full.
    '{'{ACT_ADD_REL, 32'd5, 32'd0, 8'h55, 5'd5}, 1'b1,
      '{KIND_ABORTED, 8'h55, 5'd5, 32'd5, 1'b1}},
    // Drain all but the last entry, then the last one.
    '{'{ACT_POLL, 32'h7FFF_FFFF, 32'd0, 8'h00, 5'd0}, 1'b0, UNTYPED},
    '{'{ACT_POLL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 5'd31}, 1'b0, UNTYPED}
  };

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    req_t        r;
    logic [31:0] cur_now;
    int          sel;
    int          gap;
    bit          calm;

    // Hold reset, then release it once.
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table; idle now and then between rows.
    foreach (directed_rows[i]) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
      issue_request(directed_rows[i].req, gap, 1'b0);
      mirror_request(directed_rows[i].req, !directed_rows[i].has_want);
      if (directed_rows[i].has_want) pending_results.push_back(directed_rows[i].want);
    end

    // Random part: mostly adds and polls on a slowly advancing clock, so the
    // queue fills, spills into full and drains in order; the rest is noise.
    cur_now = $urandom_range(0, 32'h7FFF_FFFF);
    for (int k = 0; k < RAND_ITEMS; k++) begin
      r.owner         = 8'($urandom);
      r.signal_number = 5'($urandom);
      // Jump the clock now and then, sometimes just below the wrap point.
      if ($urandom_range(0, 99) < 3) begin
        cur_now = ($urandom_range(0, 1) == 1) ? $urandom
                                              : 32'hFFFF_FFFF - 32'($urandom_range(0, 400));
      end
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        r.action = ACT_ADD_REL;
        cur_now += 32'($urandom_range(0, 3));
        r.now = cur_now;
        if ($urandom_range(0, 19) == 0) r.amount = 32'd0;
        else if ($urandom_range(0, 9) == 0) r.amount = ($urandom_range(0, 1) == 1) ? 32'd50 : 32'd100;
        else r.amount = 32'($urandom_range(1, 300));
      end else if (sel < 65) begin
        r.action = ACT_ADD_ABS;
        cur_now += 32'($urandom_range(0, 3));
        r.now = cur_now;
        if ($urandom_range(0, 9) == 0) r.amount = cur_now - 32'($urandom_range(0, 100));
        else r.amount = cur_now + 32'($urandom_range(0, 300));
      end else if (sel < 90) begin
        r.action = ACT_POLL;
        cur_now += 32'($urandom_range(0, 120));
        r.now = cur_now;
        r.amount = $urandom;
      end else if (sel < 96) begin
        r.action = 2'($urandom_range(0, 3));
        r.now = $urandom;
        r.amount = $urandom;
      end else begin
        r.action = ACT_UNUSED;
        r.now = $urandom;
        r.amount = $urandom;
      end

      calm = (k >= RAND_ITEMS - CALM_ITEMS);
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
      // Twice in the run, pause until every owed result has come.
      issue_request(r, gap, (k == RAND_ITEMS / 3) || (k == 2 * RAND_ITEMS / 3));
      mirror_request(r, 1'b1);
    end

    // Drop start, wait for the last owed result, then let the block settle.
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests: %0d added, %0d aborted, %0d full, %0d expired, %0d polls.",
             requests_sent, seen_added, seen_aborted, seen_full, seen_expired, seen_polls);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Stop a hung run long after the slowest correct one would have ended.
  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d results still owed", $time, pending_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
